// ----- src/cmld_pkg.sv -----
// Shared types, constants and character helpers for the CAN monitor line deframer.
// No dependencies.
package cmld_pkg;

  localparam int unsigned RecordLenDef = 20;
  localparam int unsigned IdCharsDef   = 3;
  localparam int unsigned DataCharsDef = 16;

  localparam int unsigned IdW      = 12;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned OutDataW = 80;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PARSE,
    ST_EMIT
  } cmld_state_e;

  typedef struct packed {
    logic wr;
    logic clr_acc;
    logic shift;
    logic scan_hit;
    logic parse_step;
    logic cnt_clr;
    logic cnt_inc;
    logic load_out;
  } cmld_cmd_t;

  typedef struct packed {
    logic full;
    logic rx_cr;
    logic head_cr;
    logic head_nul;
    logic scan_end;
    logic parse_end;
    logic out_free;
  } cmld_status_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } cmld_hex_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic cmld_hex_t hex_val(input logic [7:0] c);
    cmld_hex_t h;
    h.valid = 1'b1;
    h.val   = 4'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      h.val = 4'(c - 8'h30);
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      h.val = 4'(c - 8'h57);
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- src/cmld_datapath.sv -----
// Datapath: record buffer (shift line with indexed write), fill and step counters,
// field parsers and the output register. Depends on cmld_pkg.
module cmld_datapath #(
  parameter int unsigned RECORD_LEN = cmld_pkg::RecordLenDef,
  parameter int unsigned ID_CHARS   = cmld_pkg::IdCharsDef,
  parameter int unsigned DATA_CHARS = cmld_pkg::DataCharsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmld_pkg::cmld_cmd_t        cmd_i,
  output cmld_pkg::cmld_status_t     status_o,
  input  logic [7:0]                 rx_byte_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [cmld_pkg::IdW-1:0]   can_id_o,
  output logic [cmld_pkg::PayloadW-1:0] can_payload_o
);

  localparam int unsigned FillW = $clog2(RECORD_LEN);
  localparam int unsigned StepW = $clog2(RECORD_LEN + ID_CHARS + DATA_CHARS);

  logic [7:0]            buf_q [RECORD_LEN];
  logic [FillW-1:0]      fill_q, fill_d;
  logic [StepW-1:0]      cnt_q, cnt_d;
  logic                  skip_q, skip_d;
  logic                  stop_q, stop_d;
  logic [cmld_pkg::IdW-1:0]      id_acc_q, id_acc_d;
  logic [cmld_pkg::PayloadW-1:0] data_acc_q, data_acc_d;
  logic                  out_valid_q, out_valid_d;
  logic [cmld_pkg::IdW-1:0]      out_id_q;
  logic [cmld_pkg::PayloadW-1:0] out_data_q;

  logic [7:0]            head;
  logic                  head_ws;
  cmld_pkg::cmld_hex_t   head_hex;
  logic                  in_id;
  logic                  id_last;

  assign head     = buf_q[0];
  assign head_ws  = cmld_pkg::is_ws(head);
  assign head_hex = cmld_pkg::hex_val(head);
  assign in_id    = cnt_q < StepW'(ID_CHARS);
  assign id_last  = cnt_q == StepW'(ID_CHARS - 1);

  assign status_o.full      = fill_q == FillW'(RECORD_LEN - 1);
  assign status_o.rx_cr     = rx_byte_i == cmld_pkg::CharCr;
  assign status_o.head_cr   = head == cmld_pkg::CharCr;
  assign status_o.head_nul  = head == cmld_pkg::CharNul;
  assign status_o.scan_end  = cnt_q == StepW'(RECORD_LEN - 1);
  assign status_o.parse_end = cnt_q == StepW'(ID_CHARS + DATA_CHARS - 1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.wr) begin
      fill_d = status_o.full ? '0 : fill_q + FillW'(1);
    end else if (cmd_i.scan_hit) begin
      fill_d = FillW'(RECORD_LEN - 1) - cnt_q[FillW-1:0];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + StepW'(1);
    end
  end

  always_comb begin
    skip_d     = skip_q;
    stop_d     = stop_q;
    id_acc_d   = id_acc_q;
    data_acc_d = data_acc_q;
    if (cmd_i.clr_acc) begin
      skip_d     = 1'b1;
      stop_d     = 1'b0;
      id_acc_d   = '0;
      data_acc_d = '0;
    end else if (cmd_i.parse_step) begin
      if (!(skip_q && head_ws)) begin
        skip_d = 1'b0;
        if (!stop_q) begin
          if (head_hex.valid) begin
            if (in_id) begin
              id_acc_d = {id_acc_q[cmld_pkg::IdW-5:0], head_hex.val};
            end else begin
              data_acc_d = {data_acc_q[cmld_pkg::PayloadW-5:0], head_hex.val};
            end
          end else begin
            stop_d = 1'b1;
          end
        end
      end
      if (id_last) begin
        skip_d = 1'b1;
        stop_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      cnt_q       <= '0;
      skip_q      <= 1'b1;
      stop_q      <= 1'b0;
      id_acc_q    <= '0;
      data_acc_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      skip_q      <= skip_d;
      stop_q      <= stop_d;
      id_acc_q    <= id_acc_d;
      data_acc_q  <= data_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      buf_q[fill_q] <= rx_byte_i;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < RECORD_LEN - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
      buf_q[RECORD_LEN-1] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_id_q   <= id_acc_q;
      out_data_q <= data_acc_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign can_id_o      = out_id_q;
  assign can_payload_o = out_data_q;

`ifndef SYNTH
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while a result waits");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(RECORD_LEN - 1))
    else $error("fill count beyond record length");

  a_resync_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_hit |=> fill_q != '0)
    else $error("resync left an empty record");

  a_no_wr_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wr && (cmd_i.shift || cmd_i.parse_step)))
    else $error("buffer write collides with shift");
`endif

endmodule

// ----- src/cmld_ctrl.sv -----
// Controller FSM: sequences byte writes, resync scan, field parsing and result hand-off.
// Depends on cmld_pkg.
module cmld_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cmld_pkg::cmld_status_t status_i,
  output cmld_pkg::cmld_cmd_t    cmd_o
);

  cmld_pkg::cmld_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cmld_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.full) begin
          state_d = status_i.rx_cr ? cmld_pkg::ST_PARSE : cmld_pkg::ST_SCAN;
        end
      end
      cmld_pkg::ST_SCAN: begin
        if (status_i.scan_end || status_i.head_cr || status_i.head_nul) begin
          state_d = cmld_pkg::ST_IDLE;
        end
      end
      cmld_pkg::ST_PARSE: begin
        if (status_i.parse_end) begin
          state_d = cmld_pkg::ST_EMIT;
        end
      end
      cmld_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = cmld_pkg::ST_IDLE;
        end
      end
      default: state_d = cmld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      cmld_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.wr      = 1'b1;
          cmd_o.clr_acc = status_i.full && status_i.rx_cr;
          cmd_o.cnt_clr = 1'b1;
        end
      end
      cmld_pkg::ST_SCAN: begin
        priority if (status_i.scan_end || status_i.head_nul) begin
          cmd_o.cnt_clr = 1'b1;
        end else if (status_i.head_cr) begin
          cmd_o.shift    = 1'b1;
          cmd_o.scan_hit = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
        end else begin
          cmd_o.shift   = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      cmld_pkg::ST_PARSE: begin
        cmd_o.parse_step = 1'b1;
        cmd_o.shift      = 1'b1;
        cmd_o.cnt_inc    = !status_i.parse_end;
        cmd_o.cnt_clr    = status_i.parse_end;
      end
      cmld_pkg::ST_EMIT: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmld_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_parse_follows_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmld_pkg::ST_IDLE && in_valid_i && status_i.full && status_i.rx_cr)
      |=> state_q == cmld_pkg::ST_PARSE)
    else $error("full record ending in CR not parsed");

  a_emit_after_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmld_pkg::ST_PARSE && status_i.parse_end) |=> state_q == cmld_pkg::ST_EMIT)
    else $error("parse end did not lead to emit");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.shift && !cmd_o.load_out)
    else $error("input taken during buffer work");
`endif

endmodule

// ----- src/can_monitor_line_deframer.sv -----
// CAN monitor line deframer: one received byte per transfer; a full record ending in CR gives
// id and payload. A byte that does not complete a record is only written to the buffer. A
// record ending in CR is parsed one character per cycle from the buffer head, then its id and
// payload go into the output register; a full record without a CR at its end starts a resync
// scan. Throughput: 1 byte per cycle between records; the input stalls during scan, parsing
// and output load, and the load waits while an earlier result is still held. Reset: rst_ni
// asynchronous active low clears fill count, FSM and output valid.
module can_monitor_line_deframer #(
  parameter int unsigned RECORD_LEN = cmld_pkg::RecordLenDef,
  parameter int unsigned ID_CHARS   = cmld_pkg::IdCharsDef,
  parameter int unsigned DATA_CHARS = cmld_pkg::DataCharsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cmld_pkg::OutDataW-1:0] m_axis_tdata   // [11:0] can_id, [75:12] can_payload
);

  cmld_pkg::cmld_cmd_t    cmd;
  cmld_pkg::cmld_status_t status;
  logic [cmld_pkg::IdW-1:0]      can_id;
  logic [cmld_pkg::PayloadW-1:0] can_payload;

  cmld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cmld_datapath #(
    .RECORD_LEN (RECORD_LEN),
    .ID_CHARS   (ID_CHARS),
    .DATA_CHARS (DATA_CHARS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .rx_byte_i     (s_axis_tdata),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .can_id_o      (can_id),
    .can_payload_o (can_payload)
  );

  assign m_axis_tdata = {4'b0000, can_payload, can_id};

endmodule

// ----- verif/can_monitor_line_deframer_checker.sv -----
// Checker for the CAN monitor line deframer: watches both stream channels, predicts each
// parsed frame from the accepted bytes and compares it with the frames the block returns.
// Depends on cmld_pkg for the record geometry and character codes.
module can_monitor_line_deframer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [cmld_pkg::OutDataW-1:0] m_axis_tdata,   // [11:0] can_id, [75:12] can_payload
  output int                            mismatch_count_o,
  output int                            pending_count_o
);

  localparam int LineLen   = cmld_pkg::RecordLenDef;
  localparam int IdChars   = cmld_pkg::IdCharsDef;
  localparam int DataChars = cmld_pkg::DataCharsDef;

  typedef struct packed {
    logic [cmld_pkg::IdW-1:0]      can_id;
    logic [cmld_pkg::PayloadW-1:0] payload;
  } can_frame_t;

  logic [7:0] line_buf [LineLen];
  int         line_fill;
  can_frame_t expected_frames [$];
  int         mismatches;

  assign mismatch_count_o = mismatches;

  // leading whitespace skipped, then hex digits until the first other byte
  function automatic logic [63:0] hex_field_value(input int start, input int len);
    logic [63:0] acc;
    logic [7:0]  c;
    logic [3:0]  nib;
    bit          in_digits;
    bit          stopped;
    bit          is_hex;
    acc       = '0;
    in_digits = 1'b0;
    stopped   = 1'b0;
    for (int i = 0; i < len; i++) begin
      c = line_buf[start + i];
      if (!stopped) begin
        if (!in_digits && (c == cmld_pkg::CharSpace ||
                           (c >= cmld_pkg::CharTab && c <= cmld_pkg::CharCr))) begin
          continue;
        end
        in_digits = 1'b1;
        is_hex    = 1'b1;
        nib       = '0;
        if (c >= "0" && c <= "9") begin
          nib = c[3:0];
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
          nib = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
          is_hex = 1'b0;
        end
        if (is_hex) begin
          acc = {acc[59:0], nib};
        end else begin
          stopped = 1'b1;
        end
      end
    end
    return acc;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    int          k;
    int          tail;
    logic [63:0] id_value;
    can_frame_t  frame;
    if (line_fill >= LineLen) line_fill = 0;
    line_buf[line_fill] = b;
    line_fill++;
    if (line_fill < LineLen) return;
    if (line_buf[LineLen-1] != cmld_pkg::CharCr) begin
      k = 0;
      while (k < LineLen - 1 && line_buf[k] != cmld_pkg::CharNul &&
             line_buf[k] != cmld_pkg::CharCr) begin
        k++;
      end
      if (k < LineLen - 1 && line_buf[k] == cmld_pkg::CharCr) begin
        tail = LineLen - 1 - k;
        for (int i = 0; i < tail; i++) line_buf[i] = line_buf[k + 1 + i];
        line_fill = tail;
      end else begin
        line_fill = 0;
      end
    end else begin
      line_fill     = 0;
      id_value      = hex_field_value(0, IdChars);
      frame.can_id  = id_value[cmld_pkg::IdW-1:0];
      frame.payload = hex_field_value(IdChars, DataChars);
      expected_frames.push_back(frame);
    end
  endtask

  task automatic check_frame(input logic [cmld_pkg::OutDataW-1:0] data);
    can_frame_t got;
    can_frame_t want;
    got.can_id  = data[11:0];
    got.payload = data[75:12];
    if (expected_frames.size() == 0) begin
      if (mismatches < 10) begin
        $display("[%0t] unexpected frame: id %h payload %h", $realtime, got.can_id,
                 got.payload);
      end
      mismatches++;
      return;
    end
    want = expected_frames.pop_front();
    if (got.can_id !== want.can_id) begin
      if (mismatches < 10) begin
        $display("[%0t] can_id mismatch: expected %h, got %h", $realtime, want.can_id,
                 got.can_id);
      end
      mismatches++;
    end
    if (got.payload !== want.payload) begin
      if (mismatches < 10) begin
        $display("[%0t] payload mismatch: expected %h, got %h", $realtime, want.payload,
                 got.payload);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_fill = 0;
      mismatches = 0;
      expected_frames.delete();
      pending_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_frame(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata);
      pending_count_o <= expected_frames.size();
    end
  end

endmodule

// ----- verif/can_monitor_line_deframer_tb.sv -----
// Testbench top for the CAN monitor line deframer: drives byte streams (directed lines,
// random records, broken lines, noise) under several idle/stall mixes and gives the verdict.
// Depends on cmld_pkg, can_monitor_line_deframer and can_monitor_line_deframer_checker.
module can_monitor_line_deframer_tb;

  localparam int LineLen       = cmld_pkg::RecordLenDef;
  localparam int IdChars       = cmld_pkg::IdCharsDef;
  localparam int BytesPerPhase = 500;
  localparam int HoldCycles    = 600;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 40;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;   // [7:0] rx_byte
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [cmld_pkg::OutDataW-1:0] m_axis_tdata;         // [11:0] can_id, [75:12] can_payload

  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  logic long_hold_req  = 1'b0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;
  int   bytes_sent     = 0;
  int   mismatch_count;
  int   pending_count;

  can_monitor_line_deframer dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  can_monitor_line_deframer_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (long_hold_req) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    m_axis_tready <= !long_hold_req && hold_left == 0 &&
                     $urandom_range(99) >= sink_stall_pct;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic feed_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
  endtask

  task automatic feed_line(input string id_txt, input string data_txt);
    feed_text(id_txt);
    feed_text(data_txt);
    feed_byte(cmld_pkg::CharCr);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  function automatic logic [7:0] rand_ws_char();
    case ($urandom_range(5))
      0:       return cmld_pkg::CharTab;
      1:       return 8'h0A;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return cmld_pkg::CharCr;
      default: return cmld_pkg::CharSpace;
    endcase
  endfunction

  // well-formed line with random digits, sometimes padded or cut short by a non-hex byte
  task automatic feed_random_line();
    logic [7:0] line [LineLen];
    int         n;
    int         p;
    for (int i = 0; i < LineLen - 1; i++) line[i] = rand_hex_char();
    line[LineLen-1] = cmld_pkg::CharCr;
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(1, IdChars - 1);
      for (int i = 0; i < n; i++) line[i] = rand_ws_char();
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) line[IdChars + i] = rand_ws_char();
    end
    if ($urandom_range(4) == 0) begin
      p = $urandom_range(0, LineLen - 2);
      case ($urandom_range(5))
        0:       line[p] = "+";
        1:       line[p] = "-";
        2:       line[p] = cmld_pkg::CharNul;
        3:       line[p] = cmld_pkg::CharSpace;
        4:       line[p] = 8'($urandom_range(255));
        default: begin
          line[p] = "0";
          if (p < LineLen - 2) line[p+1] = "x";
        end
      endcase
    end
    for (int i = 0; i < LineLen; i++) feed_byte(line[i]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
    int start;
    int pick;
    int n;
    src_idle_pct   =  idle_pct;
    sink_stall_pct <= stall_pct;
    start = bytes_sent;
    if (with_hold) begin
      long_hold_req <= 1'b1;
      @(posedge clk_i);
      long_hold_req <= 1'b0;
    end
    while (bytes_sent - start < BytesPerPhase) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        feed_random_line();
      end else if (pick < 80) begin
        // partial line, then a full one: misaligned until a CR lines it up again
        n = $urandom_range(1, LineLen - 2);
        repeat (n) feed_byte(rand_hex_char());
        feed_random_line();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 25)) feed_byte(8'($urandom_range(255)));
      end else begin
        // junk ending in CR, then a line: resync path
        n = $urandom_range(0, LineLen - 3);
        repeat (n) feed_byte(rand_hex_char());
        feed_byte(cmld_pkg::CharCr);
        feed_random_line();
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    feed_line("FFF", "FFFFFFFFFFFFFFFF");
    feed_line("000", "0000000000000000");
    feed_line("abc", "0123456789abcdef");
    feed_line("DEF", "FEDCBA9876543210");
    feed_line(" \t7", "\n\013\014\r  89ABCDEF01");
    feed_line("0x1", "12+4567890abcdef");
    feed_line("+12", "-123456789ABCDEF");
    feed_line("   ", "                ");
    feed_text("1");
    feed_byte(cmld_pkg::CharNul);
    feed_text("2ABCD");
    feed_byte(cmld_pkg::CharNul);
    feed_text("12345678901");
    feed_byte(cmld_pkg::CharCr);
    // no CR anywhere: line dropped
    feed_text("AAAAAAAAAAAAAAAAAAAA");
    // NUL ahead of the CR stops the search: dropped
    feed_text("12");
    feed_byte(cmld_pkg::CharNul);
    feed_text("4567");
    feed_byte(cmld_pkg::CharCr);
    feed_text("ABCDEFABCDEF");
    // CR mid-buffer: the tail moves to the front
    feed_text("ZZ");
    feed_byte(cmld_pkg::CharCr);
    feed_line("123", "0011223344556677");
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(87, 0, 1'b0);
    run_phase(0, 87, 1'b0);
    run_phase(12, 12, 1'b0);

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
